/* hw/rtl/bgd_pkg.sv */
// Shared types and constants for the button gesture detector.
// Used by bgd_core and button_gesture_detector; depends on nothing else.
`default_nettype none

package bgd_pkg;

	localparam int TIME_BITS_DEFAULT = 32;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int DEBOUNCE_W = 10;
	localparam int WINDOW_W   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LOW   = 2'd0,
		REG_DEBOUNCE     = 2'd1,
		REG_TRIPLE_WIN   = 2'd2,
		REG_LONG_PRESS   = 2'd3
	} bgd_reg_idx_t;

	localparam logic                  ACTIVE_LOW_RST = 1'b1;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 10'd35;
	localparam logic [WINDOW_W-1:0]   TRIPLE_WIN_RST = 16'd1500;
	localparam logic [WINDOW_W-1:0]   LONG_PRESS_RST = 16'd2000;

	typedef struct packed {
		logic                  active_low;
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic [WINDOW_W-1:0]   triple_window_ms;
		logic [WINDOW_W-1:0]   long_press_ms;
	} bgd_cfg_t;

	typedef struct packed {
		logic debounced_pressed;
		logic sleep_request;
		logic mode_toggle;
	} bgd_result_t;

endpackage : bgd_pkg

`default_nettype wire

/* hw/rtl/bgd_core.sv */
// Gesture state and per-tick evaluation: debounce, press history and hold timer.
// Depends on bgd_pkg for the configuration and result structs.
`default_nettype none

module bgd_core #(
	parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step_en,
	input  wire                  pin_level,
	input  bgd_pkg::bgd_cfg_t    cfg,
	output bgd_pkg::bgd_result_t result
);
	import bgd_pkg::*;

	logic [TIME_BITS-1:0] time_q;
	logic                 acc_q;
	logic [TIME_BITS-1:0] last_change_q;
	logic [TIME_BITS-1:0] hist_q [3];
	logic [TIME_BITS-1:0] hold_start_q;
	logic                 long_done_q;

	logic                 pressed;
	logic                 change;
	logic                 new_press;
	logic [TIME_BITS-1:0] hold_eff;
	logic                 long_done_eff;
	logic [TIME_BITS-1:0] since_change;
	logic [TIME_BITS-1:0] since_oldest;
	logic [TIME_BITS-1:0] held_for;
	logic                 sleep;
	logic                 toggle;

	always_comb begin
		pressed      = cfg.active_low ? ~pin_level : pin_level;
		since_change = time_q - last_change_q;
		change       = (pressed != acc_q) && (since_change > TIME_BITS'(cfg.debounce_ms));
		new_press    = change && pressed;

		// The entry that becomes the oldest after a press is the current middle one.
		since_oldest = time_q - hist_q[1];
		sleep        = new_press && (hist_q[1] != '0) &&
			(since_oldest < TIME_BITS'(cfg.triple_window_ms));

		if (change) begin
			hold_eff = pressed ? time_q : '0;
		end else begin
			hold_eff = hold_start_q;
		end
		long_done_eff = new_press ? 1'b0 : long_done_q;
		held_for      = time_q - hold_eff;
		toggle        = pressed && (hold_eff != '0) && !long_done_eff &&
			(held_for >= TIME_BITS'(cfg.long_press_ms));

		result.debounced_pressed = change ? pressed : acc_q;
		result.sleep_request     = sleep;
		result.mode_toggle       = toggle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			acc_q         <= 1'b0;
			last_change_q <= '0;
			hist_q[0]     <= '0;
			hist_q[1]     <= '0;
			hist_q[2]     <= '0;
			hold_start_q  <= '0;
			long_done_q   <= 1'b0;
		end else if (step_en) begin
			time_q <= time_q + TIME_BITS'(1);
			if (change) begin
				acc_q         <= pressed;
				last_change_q <= time_q;
			end
			if (new_press) begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= time_q;
			end
			hold_start_q <= hold_eff;
			long_done_q  <= long_done_eff || toggle;
		end
	end

	a_time_advances: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> time_q == $past(time_q) + TIME_BITS'(1))
		else $error("tick counter did not advance by one");

	a_sleep_on_press: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.sleep_request |=> acc_q && hist_q[2] == $past(time_q))
		else $error("sleep request without a recorded press");

	a_toggle_marks_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && result.mode_toggle |=> long_done_q)
		else $error("mode toggle did not mark the hold as done");

	a_toggle_once: assert property (@(posedge clk) disable iff (!arst_n)
		long_done_q && !new_press |-> !result.mode_toggle)
		else $error("second mode toggle within one hold");

	a_release_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && change && !pressed |=> hold_start_q == '0 && !acc_q)
		else $error("accepted release left a hold running");

endmodule : bgd_core

`default_nettype wire

/* hw/rtl/button_gesture_detector.sv */
// Button gesture detector: debounce, triple-press sleep request, long-press mode toggle.
//
// One beat on the input channel is one millisecond tick carrying the raw pin level;
// every input beat yields exactly one output beat with the debounced pressed state
// and the two one-tick pulses (sleep request, mode toggle).
// Path: an input beat is held in an input register and evaluated into the output
// register as soon as that register is empty or being emptied. Throughput: one beat per
// cycle while the receiver keeps out_ready high; the evaluation is a few subtractions
// and compares of the time counter width between those two registers.
// A stalled receiver holds the output register; the input register still drains
// into it as soon as it frees, and in_ready falls only while both are full.
// Reset clears the tick counter, the press history and the hold timer and loads the
// register defaults (active low, 35 ms debounce, 1500 ms window, 2000 ms long press).
// The first accepted change after reset needs a tick time above the debounce time.
// Configuration writes take effect at once and belong in idle periods.
// Depends on bgd_pkg and bgd_core.
`default_nettype none

module button_gesture_detector #(
	parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEFAULT
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire  [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [bgd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           pin_level,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          debounced_pressed,
	output logic                          sleep_request,
	output logic                          mode_toggle
);
	import bgd_pkg::*;

	bgd_cfg_t    cfg_q;
	logic        valid_s1;
	logic        pin_s1;
	logic        out_valid_q;
	bgd_result_t res_q;
	bgd_result_t res_next;
	logic        advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low       <= ACTIVE_LOW_RST;
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.triple_window_ms <= TRIPLE_WIN_RST;
			cfg_q.long_press_ms    <= LONG_PRESS_RST;
		end else if (cfg_wr_en) begin
			unique case (bgd_reg_idx_t'(cfg_index))
				REG_ACTIVE_LOW: cfg_q.active_low       <= cfg_data[0];
				REG_DEBOUNCE:   cfg_q.debounce_ms      <= cfg_data[DEBOUNCE_W-1:0];
				REG_TRIPLE_WIN: cfg_q.triple_window_ms <= cfg_data[WINDOW_W-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ms    <= cfg_data[WINDOW_W-1:0];
			endcase
		end
	end

	// The held beat moves on whenever the output register is empty or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
		end
	end

	bgd_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.pin_level(pin_s1),
		.cfg      (cfg_q),
		.result   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid         = out_valid_q;
	assign debounced_pressed = res_q.debounced_pressed;
	assign sleep_request     = res_q.sleep_request;
	assign mode_toggle       = res_q.mode_toggle;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("result register overwritten while stalled");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken with both stages full");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("evaluated beat not offered at the output");

endmodule : button_gesture_detector

`default_nettype wire

/* test/tb_button_gesture_detector.sv */
`timescale 1ns / 100ps
// Testbench for button_gesture_detector: directed and random millisecond ticks, each
// result beat checked field by field against a behavioural model of debounce and gestures.
// Depends on bgd_pkg and the button_gesture_detector RTL.

module tb_button_gesture_detector;
	import bgd_pkg::*;

	// The block runs with the narrowest tick counter that it supports.
	localparam int MS_BITS = 16;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 300;

	typedef logic [MS_BITS-1:0] ms_t;
	typedef struct packed {
		logic level;
		logic after_drain;
	} tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic pin_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic debounced_pressed;
	logic sleep_request;
	logic mode_toggle;

	tick_t tick_queue[$];
	bgd_result_t due_results[$];
	int unsigned fail_count = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned beats_seen = 0;
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;

	// Shadow of the settings and the gesture state of the block.
	bgd_cfg_t cfg_shadow;
	ms_t ms_now = '0;
	ms_t last_edge_ms = '0;
	ms_t hold_since_ms = '0;
	ms_t press_ms[3];
	logic held = 1'b0;
	logic toggle_done = 1'b0;

	always #1 clk = ~clk;

	button_gesture_detector #(.TIME_BITS(MS_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.debounced_pressed(debounced_pressed),
		.sleep_request(sleep_request),
		.mode_toggle(mode_toggle)
	);

	function automatic void debounce_tick(input logic level);
		logic pressed;
		ms_t since_edge;
		ms_t since_first;
		ms_t since_hold;
		bgd_result_t res;
		pressed = cfg_shadow.active_low ? ~level : level;
		res = '0;
		since_edge = ms_now - last_edge_ms;
		if (pressed != held && since_edge > MS_BITS'(cfg_shadow.debounce_ms)) begin
			last_edge_ms = ms_now;
			held = pressed;
			if (pressed) begin
				hold_since_ms = ms_now;
				toggle_done = 1'b0;
				press_ms[0] = press_ms[1];
				press_ms[1] = press_ms[2];
				press_ms[2] = ms_now;
				// A zero time stands for an unset entry, so it never completes a triple.
				since_first = ms_now - press_ms[0];
				res.sleep_request = (press_ms[0] != '0) &&
					(since_first < MS_BITS'(cfg_shadow.triple_window_ms));
			end else begin
				hold_since_ms = '0;
			end
		end
		// The hold check follows the raw level, not the debounced state.
		since_hold = ms_now - hold_since_ms;
		if (pressed && hold_since_ms != '0 && !toggle_done &&
				since_hold >= MS_BITS'(cfg_shadow.long_press_ms)) begin
			toggle_done = 1'b1;
			res.mode_toggle = 1'b1;
		end
		ms_now = ms_now + 1'b1;
		res.debounced_pressed = held;
		due_results.push_back(res);
	endfunction

	task automatic add_run(input logic pressed, input int unsigned n,
			input logic after_drain = 1'b0);
		tick_t t;
		for (int unsigned i = 0; i < n; i++) begin
			t.level = pressed ^ cfg_shadow.active_low;
			t.after_drain = after_drain && (i == 0);
			tick_queue.push_back(t);
		end
	endtask

	// Checked between edges, once the sender's updates for the last edge have settled.
	task automatic wait_idle();
		while (tick_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input bgd_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_settings(input logic al, input int unsigned deb,
			input int unsigned win, input int unsigned lp);
		wait_idle();
		write_reg(REG_ACTIVE_LOW, CFG_DATA_W'(al));
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		write_reg(REG_TRIPLE_WIN, CFG_DATA_W'(win));
		write_reg(REG_LONG_PRESS, CFG_DATA_W'(lp));
		cfg_shadow.active_low = al;
		cfg_shadow.debounce_ms = DEBOUNCE_W'(deb);
		cfg_shadow.triple_window_ms = WINDOW_W'(win);
		cfg_shadow.long_press_ms = WINDOW_W'(lp);
	endtask

	// Alternating press and release runs sized around the current settings, with
	// some short bounces mixed in.
	task automatic add_random_gestures(input int unsigned count);
		int unsigned done_n;
		int unsigned len;
		int unsigned deb;
		int unsigned win;
		int unsigned lp;
		logic pressed;
		deb = 32'(cfg_shadow.debounce_ms);
		win = 32'(cfg_shadow.triple_window_ms);
		lp = 32'(cfg_shadow.long_press_ms);
		done_n = 0;
		pressed = 1'($urandom_range(0, 1));
		while (done_n < count) begin
			if ($urandom_range(0, 4) == 0)
				len = $urandom_range(1, deb + 1);
			else if (pressed)
				len = $urandom_range(deb + 1, deb + lp + 4);
			else
				len = $urandom_range(deb + 1, deb + win / 2 + 4);
			add_run(pressed, len);
			done_n += len;
			pressed = ~pressed;
		end
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pin_level <= 1'b0;
		end else begin : send
			tick_t nxt;
			if (in_valid && in_ready)
				debounce_tick(pin_level);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_queue.size() != 0 &&
						(!tick_queue[0].after_drain || due_results.size() == 0)) begin
					nxt = tick_queue.pop_front();
					in_valid <= 1'b1;
					pin_level <= nxt.level;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and stalls on a slowly rotating pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin : receive
			bgd_result_t want;
			int unsigned slot;
			if (out_valid && out_ready) begin
				beats_seen++;
				if (due_results.size() == 0) begin
					$error("result beat with no tick waiting for it");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (debounced_pressed !== want.debounced_pressed) begin
						$error("debounced_pressed: expected %0b, got %0b",
							want.debounced_pressed, debounced_pressed);
						fail_count++;
					end
					if (sleep_request !== want.sleep_request) begin
						$error("sleep_request: expected %0b, got %0b",
							want.sleep_request, sleep_request);
						fail_count++;
					end
					if (mode_toggle !== want.mode_toggle) begin
						$error("mode_toggle: expected %0b, got %0b",
							want.mode_toggle, mode_toggle);
						fail_count++;
					end
				end
				// A long hold-off, so that the block fills and pushes back on its input.
				if (beats_seen == 400)
					hold_left = LONG_HOLD;
			end
			rx_cycle++;
			slot = (rx_cycle / 97) % 4;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (slot < 2) begin
				out_ready <= 1'b1;
			end else if (slot == 2) begin
				out_ready <= 1'($urandom_range(0, 1));
			end else begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		cfg_shadow.active_low = ACTIVE_LOW_RST;
		cfg_shadow.debounce_ms = DEBOUNCE_RST;
		cfg_shadow.triple_window_ms = TRIPLE_WIN_RST;
		cfg_shadow.long_press_ms = LONG_PRESS_RST;
		press_ms[0] = '0;
		press_ms[1] = '0;
		press_ms[2] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: the first press is only taken once the tick time passes
		// the debounce time, and a quick release after it is ignored.
		add_run(1'b1, 40);
		add_run(1'b0, 6);
		add_run(1'b1, 3);
		add_run(1'b0, 40);

		// No debounce and no hold time: every edge counts and the toggle fires on the
		// press itself; three quick presses request sleep.
		apply_settings(1'b1, 0, 20, 0);
		add_run(1'b0, 2);
		repeat (3) begin
			add_run(1'b1, 1);
			add_run(1'b0, 1);
		end
		add_run(1'b1, 3);
		add_run(1'b0, 2);

		// Presses spaced exactly one window apart do not count; one tick wider does.
		apply_settings(1'b1, 0, 4, 2);
		repeat (3) begin
			add_run(1'b1, 1);
			add_run(1'b0, 1);
		end
		apply_settings(1'b1, 0, 5, 2);
		repeat (3) begin
			add_run(1'b1, 1);
			add_run(1'b0, 1);
		end
		add_run(1'b1, 4);
		add_run(1'b0, 2);

		// Active-high pin with the window and the hold time at their top values.
		apply_settings(1'b0, 40, 16'hFFFF, 16'hFFFF);
		add_run(1'b1, 50);
		add_run(1'b0, 45);
		add_run(1'b1, 45);
		add_run(1'b0, 3);

		// An empty window never requests sleep; a short release after a hold is accepted, and
		// the re-press after it starts a new hold that ends before the toggle time.
		apply_settings(1'b1, 3, 0, 5);
		repeat (3) begin
			add_run(1'b1, 9);
			add_run(1'b0, 2);
			add_run(1'b1, 4);
			add_run(1'b0, 6);
		end

		for (int ph = 0; ph < 5; ph++) begin
			apply_settings(1'($urandom_range(0, 1)), $urandom_range(0, 6),
				$urandom_range(0, 40), $urandom_range(0, 30));
			add_random_gestures(20);
			// The sender holds this beat back until every result has come.
			if (ph == 2)
				add_run(1'b0, 4, 1'b1);
			add_random_gestures(20);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_core.sv
hw/rtl/button_gesture_detector.sv
test/tb_button_gesture_detector.sv
